FILE: rtl/stcseg_pkg.sv
package stcseg_pkg;

  localparam int unsigned TIME_WIDTH_DEFAULT = 32;

  // Register reset values, milliseconds
  localparam int unsigned PAD_TIME_RESET       = 300;
  localparam int unsigned MIN_CLIP_TIME_RESET  = 500;
  localparam int unsigned TOTAL_DURATION_RESET = 0;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAD_TIME       = 2'd0,
    CFG_MIN_CLIP_TIME  = 2'd1,
    CFG_TOTAL_DURATION = 2'd2
  } cfg_idx_e;

  // Candidate clips handed from the tracker to the filters
  typedef struct packed {
    logic c0_valid;     // clip closed by this silence
    logic c1_valid;     // tail clip, final silence only
    logic final_item;
  } cand_ctrl_t;

endpackage

FILE: rtl/stcseg_track.sv
module stcseg_track #(
  parameter int unsigned TIME_WIDTH = stcseg_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [TIME_WIDTH-1:0]  silence_start_i,
  input  logic [TIME_WIDTH-1:0]  silence_end_i,
  input  logic                   final_silence_i,
  input  logic [TIME_WIDTH-1:0]  pad_time_i,
  input  logic [TIME_WIDTH-1:0]  total_duration_i,
  output logic                   cand_valid_o,
  input  logic                   cand_ready_i,
  output stcseg_pkg::cand_ctrl_t cand_ctrl_o,
  output logic [TIME_WIDTH-1:0]  c0_start_o,
  output logic [TIME_WIDTH-1:0]  c0_end_o,
  output logic [TIME_WIDTH-1:0]  c1_start_o
);

  // input register
  logic                  in_v_q;
  logic [TIME_WIDTH-1:0] s_q, e_q;
  logic                  fin_q;

  // recording state
  logic                  started_q;
  logic                  pend_v_q;
  logic [TIME_WIDTH-1:0] pend_start_q;
  logic [TIME_WIDTH-1:0] prev_end_q;

  // candidate register
  logic                   cand_v_q;
  stcseg_pkg::cand_ctrl_t cand_ctrl_q, cand_ctrl_d;
  logic [TIME_WIDTH-1:0]  c0_start_q, c0_end_q, c1_start_q;

  logic                  s1_ready, s0_ready, advance, in_take;
  logic [TIME_WIDTH-1:0] s_clamp, e_clamp, gap, pend_start_a, pend_start_c;
  logic                  pend_a, pend_b, pend_c, next_exists, merge, open_new;

  assign s1_ready   = !cand_v_q || cand_ready_i;
  assign advance    = in_v_q && s1_ready;
  assign s0_ready   = !in_v_q || s1_ready;
  assign in_stall_o = !s0_ready;
  assign in_take    = in_valid_i && s0_ready;

  // out-of-order times are pulled forward
  assign s_clamp = (s_q < prev_end_q) ? prev_end_q : s_q;
  assign e_clamp = (e_q < s_clamp) ? s_clamp : e_q;

  // head clip opens on the first silence unless it starts at zero
  assign pend_a       = started_q ? pend_v_q : (s_clamp != '0);
  assign pend_start_a = started_q ? pend_start_q : '0;

  assign next_exists = !fin_q || (e_clamp < total_duration_i);
  assign gap         = e_clamp - s_clamp;
  assign merge       = next_exists &&
                       ((gap < pad_time_i) || ((gap - pad_time_i) < pad_time_i));

  assign pend_b       = pend_a && merge;
  assign open_new     = next_exists && !pend_b;
  assign pend_c       = pend_b || open_new;
  assign pend_start_c = open_new ? e_clamp : pend_start_a;

  always_comb begin
    cand_ctrl_d.c0_valid   = pend_a && !merge;
    cand_ctrl_d.c1_valid   = fin_q && pend_c;
    cand_ctrl_d.final_item = fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      cand_v_q     <= 1'b0;
      started_q    <= 1'b0;
      pend_v_q     <= 1'b0;
      pend_start_q <= '0;
      prev_end_q   <= '0;
      cand_ctrl_q  <= '0;
    end else begin
      in_v_q   <= in_take || (in_v_q && !advance);
      cand_v_q <= advance || (cand_v_q && !cand_ready_i);
      if (advance) begin
        cand_ctrl_q <= cand_ctrl_d;
        if (fin_q) begin
          started_q    <= 1'b0;
          pend_v_q     <= 1'b0;
          pend_start_q <= '0;
          prev_end_q   <= '0;
        end else begin
          started_q    <= 1'b1;
          pend_v_q     <= pend_c;
          pend_start_q <= pend_start_c;
          prev_end_q   <= e_clamp;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s_q   <= silence_start_i;
      e_q   <= silence_end_i;
      fin_q <= final_silence_i;
    end
    if (advance) begin
      c0_start_q <= pend_start_a;
      c0_end_q   <= s_clamp;
      c1_start_q <= pend_start_c;
    end
  end

  assign cand_valid_o = cand_v_q;
  assign cand_ctrl_o  = cand_ctrl_q;
  assign c0_start_o   = c0_start_q;
  assign c0_end_o     = c0_end_q;
  assign c1_start_o   = c1_start_q;

endmodule

FILE: rtl/stcseg_offer.sv
module stcseg_offer #(
  parameter int unsigned TIME_WIDTH = stcseg_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic [TIME_WIDTH-1:0] start_i,
  input  logic [TIME_WIDTH-1:0] end_i,
  input  logic [TIME_WIDTH-1:0] pad_time_i,
  input  logic [TIME_WIDTH-1:0] min_clip_time_i,
  input  logic [TIME_WIDTH-1:0] total_duration_i,
  output logic                  keep_o,
  output logic [TIME_WIDTH-1:0] padded_start_o,
  output logic [TIME_WIDTH-1:0] padded_end_o
);

  logic [TIME_WIDTH:0]   end_sum;
  logic [TIME_WIDTH-1:0] ps, pe_sat, pe;
  logic                  raw_ok;

  assign raw_ok = (end_i >= start_i) && ((end_i - start_i) >= min_clip_time_i);

  assign ps      = (start_i >= pad_time_i) ? (start_i - pad_time_i) : '0;
  assign end_sum = {1'b0, end_i} + {1'b0, pad_time_i};
  // saturate on carry out
  assign pe_sat  = end_sum[TIME_WIDTH] ? '1 : end_sum[TIME_WIDTH-1:0];
  assign pe      = (pe_sat > total_duration_i) ? total_duration_i : pe_sat;

  assign keep_o         = raw_ok && (pe >= ps) && ((pe - ps) >= min_clip_time_i);
  assign padded_start_o = ps;
  assign padded_end_o   = pe;

endmodule

FILE: rtl/stcseg_outbuf.sv
module stcseg_outbuf #(
  parameter int unsigned TIME_WIDTH = stcseg_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pair_valid_i,
  output logic                  pair_ready_o,
  input  logic                  keep0_i,
  input  logic                  keep1_i,
  input  logic                  final_i,
  input  logic [TIME_WIDTH-1:0] r0_start_i,
  input  logic [TIME_WIDTH-1:0] r0_end_i,
  input  logic [TIME_WIDTH-1:0] r1_start_i,
  input  logic [TIME_WIDTH-1:0] r1_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TIME_WIDTH-1:0] clip_start_o,
  output logic [TIME_WIDTH-1:0] clip_end_o,
  output logic                  last_clip_o
);

  // slot 0 is the head; slot 1 valid implies slot 0 valid
  logic                  v0_q, v1_q;
  logic [TIME_WIDTH-1:0] st0_q, en0_q, st1_q, en1_q;
  logic                  last0_q, last1_q;
  logic                  pop, load;

  assign pop          = v0_q && !out_stall_i;
  assign pair_ready_o = !v0_q || (!v1_q && pop);
  assign load         = pair_valid_i && pair_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (load) begin
      v0_q <= keep0_i || keep1_i;
      v1_q <= keep0_i && keep1_i;
    end else if (pop) begin
      v0_q <= v1_q;
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      // compact kept results into the head slot first
      st0_q   <= keep0_i ? r0_start_i : r1_start_i;
      en0_q   <= keep0_i ? r0_end_i : r1_end_i;
      last0_q <= final_i && (keep0_i ^ keep1_i);
      st1_q   <= r1_start_i;
      en1_q   <= r1_end_i;
      last1_q <= final_i && keep0_i && keep1_i;
    end else if (pop) begin
      st0_q   <= st1_q;
      en0_q   <= en1_q;
      last0_q <= last1_q;
    end
  end

  assign out_valid_o  = v0_q;
  assign clip_start_o = st0_q;
  assign clip_end_o   = en0_q;
  assign last_clip_o  = last0_q;

endmodule

FILE: rtl/silence_to_clip_segmenter.sv
// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    silence_start_i, silence_end_i, final_silence_i
// out      source     out_valid_o / out_stall_i  clip_start_o, clip_end_o, last_clip_o
// cfg      sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One silence per cycle while out_stall_i is low: input register, tracker, candidate
// register, filters, two-slot result register. A silence that yields two clips fills
// both result slots, so the output port's one transfer per cycle sets the rate then.
// Reset clears the recording state and loads the register defaults.
// out_stall_i backs up through the stages to in_stall_o in the same cycle.
module silence_to_clip_segmenter #(
  parameter int unsigned TIME_WIDTH = stcseg_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [TIME_WIDTH-1:0]            silence_start_i,
  input  logic [TIME_WIDTH-1:0]            silence_end_i,
  input  logic                             final_silence_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [TIME_WIDTH-1:0]            clip_start_o,
  output logic [TIME_WIDTH-1:0]            clip_end_o,
  output logic                             last_clip_o,
  input  logic                             cfg_we_i,
  input  logic [stcseg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_WIDTH-1:0]            cfg_wdata_i
);

  logic [TIME_WIDTH-1:0] pad_time_q, min_clip_time_q, total_duration_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_time_q       <= TIME_WIDTH'(stcseg_pkg::PAD_TIME_RESET);
      min_clip_time_q  <= TIME_WIDTH'(stcseg_pkg::MIN_CLIP_TIME_RESET);
      total_duration_q <= TIME_WIDTH'(stcseg_pkg::TOTAL_DURATION_RESET);
    end else if (cfg_we_i) begin
      unique case (stcseg_pkg::cfg_idx_e'(cfg_idx_i))
        stcseg_pkg::CFG_PAD_TIME:       pad_time_q       <= cfg_wdata_i;
        stcseg_pkg::CFG_MIN_CLIP_TIME:  min_clip_time_q  <= cfg_wdata_i;
        stcseg_pkg::CFG_TOTAL_DURATION: total_duration_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                   cand_valid, cand_ready;
  stcseg_pkg::cand_ctrl_t cand_ctrl;
  logic [TIME_WIDTH-1:0]  c0_start, c0_end, c1_start;
  logic                   keep0, keep1;
  logic [TIME_WIDTH-1:0]  r0_start, r0_end, r1_start, r1_end;

  stcseg_track #(.TIME_WIDTH(TIME_WIDTH)) u_track (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .silence_start_i  (silence_start_i),
    .silence_end_i    (silence_end_i),
    .final_silence_i  (final_silence_i),
    .pad_time_i       (pad_time_q),
    .total_duration_i (total_duration_q),
    .cand_valid_o     (cand_valid),
    .cand_ready_i     (cand_ready),
    .cand_ctrl_o      (cand_ctrl),
    .c0_start_o       (c0_start),
    .c0_end_o         (c0_end),
    .c1_start_o       (c1_start)
  );

  stcseg_offer #(.TIME_WIDTH(TIME_WIDTH)) u_offer0 (
    .start_i          (c0_start),
    .end_i            (c0_end),
    .pad_time_i       (pad_time_q),
    .min_clip_time_i  (min_clip_time_q),
    .total_duration_i (total_duration_q),
    .keep_o           (keep0),
    .padded_start_o   (r0_start),
    .padded_end_o     (r0_end)
  );

  // tail clip runs to the end of the recording
  stcseg_offer #(.TIME_WIDTH(TIME_WIDTH)) u_offer1 (
    .start_i          (c1_start),
    .end_i            (total_duration_q),
    .pad_time_i       (pad_time_q),
    .min_clip_time_i  (min_clip_time_q),
    .total_duration_i (total_duration_q),
    .keep_o           (keep1),
    .padded_start_o   (r1_start),
    .padded_end_o     (r1_end)
  );

  stcseg_outbuf #(.TIME_WIDTH(TIME_WIDTH)) u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (cand_valid),
    .pair_ready_o (cand_ready),
    .keep0_i      (keep0 && cand_ctrl.c0_valid),
    .keep1_i      (keep1 && cand_ctrl.c1_valid),
    .final_i      (cand_ctrl.final_item),
    .r0_start_i   (r0_start),
    .r0_end_i     (r0_end),
    .r1_start_i   (r1_start),
    .r1_end_i     (r1_end),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .clip_start_o (clip_start_o),
    .clip_end_o   (clip_end_o),
    .last_clip_o  (last_clip_o)
  );

endmodule

FILE: sim/silence_to_clip_segmenter_tb.sv
`timescale 1ns / 100ps

module silence_to_clip_segmenter_tb;

  localparam int unsigned TW = stcseg_pkg::TIME_WIDTH_DEFAULT;
  localparam int unsigned ITEM_GOAL = 1750;

  typedef logic [TW-1:0] ms_t;

  typedef struct {
    ms_t  start_ms;
    ms_t  end_ms;
    logic closing;
  } clip_t;

  // Tracks the open run of clips and queues the clips each silence should produce.
  class clip_scoreboard;
    ms_t         pad_ms;
    ms_t         min_ms;
    ms_t         dur_ms;
    ms_t         prev_end;
    ms_t         run_start;
    bit          run_open;
    bit          seen;
    clip_t       expected_q[$];
    int unsigned errors;

    function new();
      pad_ms = stcseg_pkg::PAD_TIME_RESET;
      min_ms = stcseg_pkg::MIN_CLIP_TIME_RESET;
      dur_ms = stcseg_pkg::TOTAL_DURATION_RESET;
      errors = 0;
      clear_recording();
    endfunction

    function void clear_recording();
      prev_end = '0;
      run_start = '0;
      run_open = 1'b0;
      seen = 1'b0;
    endfunction

    function void set_reg(stcseg_pkg::cfg_idx_e idx, ms_t value);
      case (idx)
        stcseg_pkg::CFG_PAD_TIME:       pad_ms = value;
        stcseg_pkg::CFG_MIN_CLIP_TIME:  min_ms = value;
        stcseg_pkg::CFG_TOTAL_DURATION: dur_ms = value;
        default: ;
      endcase
    endfunction

    // Length filter, pad, clamp; queues the clip if it survives.
    function int unsigned keep_clip(ms_t a, ms_t b);
      logic [TW:0] padded_sum;
      ms_t         lo;
      ms_t         hi;
      clip_t       c;
      if (b < a || b - a < min_ms) return 0;
      lo = (a >= pad_ms) ? a - pad_ms : '0;
      padded_sum = {1'b0, b} + {1'b0, pad_ms};
      hi = padded_sum[TW] ? '1 : padded_sum[TW-1:0];
      if (hi > dur_ms) hi = dur_ms;
      if (hi < lo || hi - lo < min_ms) return 0;
      c.start_ms = lo;
      c.end_ms = hi;
      c.closing = 1'b0;
      expected_q = {expected_q, c};
      return 1;
    endfunction

    function void note_silence(ms_t s_in, ms_t e_in, logic fin);
      ms_t         s;
      ms_t         e;
      ms_t         sil_len;
      bit          more;
      int unsigned kept;
      s = s_in;
      e = e_in;
      kept = 0;
      if (s < prev_end) s = prev_end;
      if (e < s) e = s;
      if (!seen) begin
        seen = 1'b1;
        // head clip from 0 unless the recording opens with silence
        if (s != '0) begin
          run_open = 1'b1;
          run_start = '0;
        end
      end
      more = !fin || e < dur_ms;
      sil_len = e - s;
      // a silence under twice the pad joins its neighbors into one run
      if (run_open && !(more && {1'b0, sil_len} < {pad_ms, 1'b0})) begin
        kept += keep_clip(run_start, s);
        run_open = 1'b0;
      end
      if (more && !run_open) begin
        run_open = 1'b1;
        run_start = e;
      end
      prev_end = e;
      if (fin) begin
        if (run_open) kept += keep_clip(run_start, dur_ms);
        if (kept != 0) expected_q[expected_q.size() - 1].closing = 1'b1;
        clear_recording();
      end
    endfunction

    task flag_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("%0t: %s", $time, msg);
    endtask

    task check_clip(ms_t got_start, ms_t got_end, logic got_last);
      clip_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected clip [%0d, %0d] last=%0b",
                                got_start, got_end, got_last));
        return;
      end
      want = expected_q.pop_front();
      if (got_start !== want.start_ms)
        flag_mismatch($sformatf("clip_start: got %0d, expected %0d", got_start, want.start_ms));
      if (got_end !== want.end_ms)
        flag_mismatch($sformatf("clip_end: got %0d, expected %0d", got_end, want.end_ms));
      if (got_last !== want.closing)
        flag_mismatch($sformatf("last_clip: got %0b, expected %0b", got_last, want.closing));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 sil_valid = 1'b0;
  logic                 sil_stall;
  ms_t                  sil_start = '0;
  ms_t                  sil_end = '0;
  logic                 sil_final = 1'b0;
  logic                 clip_valid;
  logic                 clip_stall = 1'b0;
  ms_t                  clip_start;
  ms_t                  clip_end;
  logic                 clip_last;
  logic                 cfg_we = 1'b0;
  stcseg_pkg::cfg_idx_e cfg_idx = stcseg_pkg::CFG_PAD_TIME;
  ms_t                  cfg_wdata = '0;

  clip_scoreboard sb = new();
  int unsigned    silences_sent = 0;
  bit             no_idle = 1'b0;

  silence_to_clip_segmenter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (sil_valid),
    .in_stall_o     (sil_stall),
    .silence_start_i(sil_start),
    .silence_end_i  (sil_end),
    .final_silence_i(sil_final),
    .out_valid_o    (clip_valid),
    .out_stall_i    (clip_stall),
    .clip_start_o   (clip_start),
    .clip_end_o     (clip_end),
    .last_clip_o    (clip_last),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic ms_t clamp_ms(longint unsigned t);
    return (t > longint'({TW{1'b1}})) ? '1 : ms_t'(t);
  endfunction

  task automatic send_silence(ms_t s, ms_t e, logic fin);
    int unsigned idle;
    idle = idle_cycles();
    if (idle != 0) begin
      sil_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    sil_valid <= 1'b1;
    sil_start <= s;
    sil_end <= e;
    sil_final <= fin;
    do @(posedge clk); while (sil_stall);
    sb.note_silence(s, e, fin);
    silences_sent++;
  endtask

  // Wait until every expected clip has come out, then let the pipeline empty.
  task automatic settle();
    sil_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(ms_t pad, ms_t min_len, ms_t dur);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= stcseg_pkg::CFG_PAD_TIME;
    cfg_wdata <= pad;
    @(posedge clk);
    sb.set_reg(stcseg_pkg::CFG_PAD_TIME, pad);
    cfg_idx <= stcseg_pkg::CFG_MIN_CLIP_TIME;
    cfg_wdata <= min_len;
    @(posedge clk);
    sb.set_reg(stcseg_pkg::CFG_MIN_CLIP_TIME, min_len);
    cfg_idx <= stcseg_pkg::CFG_TOTAL_DURATION;
    cfg_wdata <= dur;
    @(posedge clk);
    sb.set_reg(stcseg_pkg::CFG_TOTAL_DURATION, dur);
    cfg_we <= 1'b0;
  endtask

  // One recording: ordered silences with random lengths, a few broken ones mixed in.
  task automatic play_recording(int unsigned count, int unsigned span);
    longint unsigned t;
    longint unsigned t_end;
    ms_t             s;
    ms_t             e;
    int unsigned     pick;
    t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span);
    for (int unsigned i = 0; i < count; i++) begin
      t_end = t + $urandom_range(0, span);
      s = clamp_ms(t);
      e = clamp_ms(t_end);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        s = $urandom();
        e = $urandom();
      end else if (pick == 1) begin
        s = $urandom_range(0, s);
      end else if (pick == 2) begin
        e = $urandom_range(0, s);
      end
      send_silence(s, e, i == count - 1);
      t = t_end + $urandom_range(0, span);
    end
  endtask

  initial begin : clip_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && clip_valid && !clip_stall) begin
        sb.check_clip(clip_start, clip_end, clip_last);
        hold = idle_cycles();
      end
      if (hold != 0) begin
        clip_stall <= 1'b1;
        hold--;
      end else begin
        clip_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned span;
    int unsigned recs;
    ms_t         pad;
    ms_t         min_len;
    ms_t         dur;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: zero duration clamps everything away
    send_silence(0, 100, 1'b0);
    send_silence(400, 900, 1'b0);
    send_silence(2000, 2100, 1'b1);

    load_regs(300, 500, 10000);
    // opens with silence, merges, runs backward, ends exactly at the duration
    send_silence(0, 1000, 1'b0);
    send_silence(3000, 3200, 1'b0);
    send_silence(5000, 6000, 1'b0);
    send_silence(4000, 4500, 1'b0);
    send_silence(9000, 8000, 1'b0);
    send_silence(9500, 10000, 1'b1);
    // head clip from zero, tail clip up to the duration
    send_silence(2000, 2100, 1'b0);
    send_silence(2600, 3000, 1'b1);
    // short clip dropped
    send_silence(100, 2000, 1'b0);
    send_silence(2300, 4000, 1'b1);

    // zero pad: a zero-length silence does not merge
    load_regs(0, 0, '1);
    send_silence(5, 5, 1'b0);
    send_silence(10, 20, 1'b0);
    send_silence(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);

    // huge pad: padded end saturates
    load_regs('1, 0, '1);
    send_silence(32'h8000_0000, 32'h8000_0001, 1'b0);
    send_silence(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);

    // nothing long enough: no clip, no last flag
    load_regs(100, '1, 5000);
    send_silence(1000, 1100, 1'b1);

    while (silences_sent < ITEM_GOAL) begin
      kind = $urandom_range(0, 11);
      no_idle = ($urandom_range(0, 4) == 0);
      span = $urandom_range(200, 4000);
      pad = $urandom_range(0, span / 3);
      min_len = $urandom_range(0, span);
      dur = $urandom_range(0, 8 * span);
      case (kind)
        0: pad = '0;
        1: pad = '1;
        2: min_len = '0;
        3: min_len = '1;
        4: dur = '0;
        5: begin
          span = 32'h1000_0000;
          pad = $urandom_range(0, span / 3);
          min_len = $urandom_range(0, span);
          dur = '1;
        end
        6: dur = '1;
        default: ;
      endcase
      load_regs(pad, min_len, dur);
      recs = $urandom_range(2, 6);
      repeat (recs) play_recording($urandom_range(1, 10), span);
    end

    settle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/stcseg_pkg.sv
rtl/stcseg_track.sv
rtl/stcseg_offer.sv
rtl/stcseg_outbuf.sv
rtl/silence_to_clip_segmenter.sv
sim/silence_to_clip_segmenter_tb.sv
